// ===== sv/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// PMT section parser package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package pmt_pkg;

   localparam int MaxDescriptors  = 16;
   localparam int MaxStreams      = 16;
   localparam int MaxSectionBytes = 1024;
   localparam int MinSectionBytes = 16;
   localparam int PosWidth        = $clog2(MaxSectionBytes + 2);

   localparam logic [11:0] HDR_OVERHEAD = 12'd13;

   localparam logic [7:0] TAG_REGISTRATION   = 8'h05;
   localparam logic [7:0] TAG_TELETEXT       = 8'h56;
   localparam logic [7:0] TAG_SUBTITLING     = 8'h59;
   localparam logic [7:0] TAG_AC3            = 8'h6A;
   localparam logic [7:0] TAG_APP_SIGNALLING = 8'h6F;
   localparam logic [7:0] TAG_AC3_AUDIO      = 8'h81;
   localparam logic [7:0] ST_SECTIONS        = 8'h05;
   localparam logic [7:0] ST_PES_PRIVATE     = 8'h06;
   localparam logic [7:0] ST_AC3             = 8'h81;
   localparam logic [31:0] ID_DRA1           = 32'h44524131;
   localparam logic [31:0] ID_AC3            = 32'h41432D33;
   localparam logic [31:0] CRC_POLY          = 32'h04C11DB7;

   localparam logic [7:0] EXP_TID_RESET = 8'd2;
   localparam logic [0:0] REG_EXP_TID   = 1'b0;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_STREAM = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      SUB_UNKNOWN  = 3'd0,
      SUB_APP_SIG  = 3'd1,
      SUB_DRA      = 3'd2,
      SUB_TELETEXT = 3'd3,
      SUB_SUBTITLE = 3'd4,
      SUB_AC3      = 3'd5
   } subtype_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_CRC      = 3'd1,
      STAT_SIZE     = 3'd2,
      STAT_LENGTH   = 3'd3,
      STAT_SECNUM   = 3'd4,
      STAT_BAD_TID  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      PH_HDR  = 4'd0,
      PH_PROG = 4'd1,
      PH_ES0  = 4'd2,
      PH_ES1  = 4'd3,
      PH_ES2  = 4'd4,
      PH_ES3  = 4'd5,
      PH_ES4  = 4'd6,
      PH_ESD  = 4'd7,
      PH_DONE = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      W_TAG  = 2'd0,
      W_LEN  = 2'd1,
      W_BODY = 2'd2,
      W_SKIP = 2'd3
   } walk_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      kind_type    record_kind;
      logic [15:0] pgm_num;
      logic [5:0]  version_and_current;
      logic [7:0]  sec_no;
      logic [7:0]  last_sec_no;
      logic [12:0] pid;
      logic [7:0]  es_type;
      logic [2:0]  es_sub;
      logic [11:0] info_length;
      logic [4:0]  item_count;
      logic [2:0]  status;
      logic        record_last;
   } rsp_type;

   function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [4:0] sat5(input logic [6:0] v);
      return (v > 7'd31) ? 5'd31 : v[4:0];
   endfunction

endpackage

// ===== sv/pmt_if.sv =====
// ----------------------------------------------------------------------------
// PMT stream channel
// Valid/ready channels carrying one payload each: req_type or rsp_type.
// ----------------------------------------------------------------------------
interface pmt_req_if import pmt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pmt_rsp_if import pmt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/pmt_csr.sv =====
// ----------------------------------------------------------------------------
// PMT configuration registers
// APB-style register port holding the expected table id.
// ----------------------------------------------------------------------------
module pmt_csr import pmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [7:0]  exp_tid
);
   logic [7:0] exp_tid_ff;
   logic       wr_en;
   logic       addr_hit;

   assign csr_pready = 1'b1;
   assign addr_hit   = (csr_paddr[2] == REG_EXP_TID) && (csr_paddr[1:0] == 2'd0);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && addr_hit;
   assign csr_prdata = addr_hit ? {24'd0, exp_tid_ff} : 32'd0;
   assign exp_tid    = exp_tid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_tid_ff <= EXP_TID_RESET;
      end else if (wr_en) begin
         exp_tid_ff <= csr_pwdata[7:0];
      end
   end
endmodule

// ===== sv/pmt_parse.sv =====
// ----------------------------------------------------------------------------
// PMT parse core
// Per-byte section parser: header, descriptor walk, stream entries, CRC.
// ----------------------------------------------------------------------------
module pmt_parse import pmt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  req_type    in_req,
   input  logic [7:0] exp_tid,
   output logic       out_valid,
   output rsp_type    out_rsp
);
   logic [PosWidth-1:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   walk_type    walk_ff, walk_in;
   logic [15:0] prog_ff, prog_in;
   logic [5:0]  ver_ff, ver_in;
   logic [7:0]  secn_ff, secn_in;
   logic [7:0]  lsec_ff, lsec_in;
   logic [12:0] pcr_ff, pcr_in;
   logic [11:0] pil_ff, pil_in;
   logic [11:0] slen_ff, slen_in;
   logic [12:0] esrem_ff, esrem_in;
   logic [12:0] drem_ff, drem_in;
   logic [7:0]  dleft_ff, dleft_in;
   logic [6:0]  dcnt_ff, dcnt_in;
   logic [6:0]  scnt_ff, scnt_in;
   logic [7:0]  est_ff, est_in;
   logic [12:0] epid_ff, epid_in;
   logic [11:0] eil_ff, eil_in;
   logic [2:0]  esub_ff, esub_in;
   logic [31:0] fid_ff, fid_in;
   logic [31:0] crc_ff, crc_in;
   logic [2:0]  err_ff, err_in;
   logic [7:0]  tag_ff, tag_in;
   logic [2:0]  idb_ff, idb_in;

   logic [7:0]  b;
   logic [PosWidth-1:0] pos, bpos;
   logic [31:0] crc_start;
   logic [11:0] w12;
   logic [12:0] rem_next;
   logic        walk_end;
   logic        in_es;
   logic        emit;
   rsp_type     rec;
   logic [2:0]  st;

   always_comb begin
      b        = in_req.data_byte;
      pos_in   = pos_ff;   phase_in = phase_ff; walk_in = walk_ff;
      prog_in  = prog_ff;  ver_in   = ver_ff;   secn_in = secn_ff; lsec_in = lsec_ff;
      pcr_in   = pcr_ff;   pil_in   = pil_ff;   slen_in = slen_ff;
      esrem_in = esrem_ff; drem_in  = drem_ff;  dleft_in = dleft_ff;
      dcnt_in  = dcnt_ff;  scnt_in  = scnt_ff;  est_in  = est_ff;
      epid_in  = epid_ff;  eil_in   = eil_ff;   esub_in = esub_ff;
      fid_in   = fid_ff;   err_in   = err_ff;   tag_in  = tag_ff; idb_in = idb_ff;
      crc_start = crc_ff;
      w12 = 12'd0; rem_next = 13'd0; walk_end = 1'b0; in_es = 1'b0;
      emit = 1'b0; rec = '0; st = STAT_OK; bpos = '0;
      if (in_req.first_byte) begin
         pos_in = '0; phase_in = PH_HDR; walk_in = W_TAG;
         prog_in = '0; ver_in = '0; secn_in = '0; lsec_in = '0; pcr_in = '0; pil_in = '0;
         slen_in = '0; esrem_in = '0; drem_in = '0; dleft_in = '0; dcnt_in = '0;
         scnt_in = '0; est_in = '0; epid_in = '0; eil_in = '0; esub_in = '0;
         fid_in = '0; err_in = '0; tag_in = '0; idb_in = '0;
         crc_start = '1;
      end
      crc_in = crc_next(crc_start, b);
      pos = pos_in;
      if (pos_in <= PosWidth'(MaxSectionBytes)) begin
         pos_in = pos_in + 1'b1;
      end
      bpos = pos_in;
      if (pos >= PosWidth'(MaxSectionBytes)) begin
         phase_in = PH_DONE;
      end
      in_es = (phase_in == PH_ESD);
      unique case (phase_in)
         PH_HDR: begin
            unique case (pos)
               PosWidth'(0): if (b != exp_tid && err_in == 3'd0) err_in = STAT_BAD_TID;
               PosWidth'(1): slen_in = {b[3:0], 8'd0};
               PosWidth'(2): begin
                  slen_in = {slen_in[11:8], b};
                  if (slen_in < 12'(MinSectionBytes - 3) || slen_in > 12'(MaxSectionBytes - 3))
                  begin
                     if (err_in == 3'd0) err_in = STAT_LENGTH;
                     phase_in = PH_DONE;
                  end
               end
               PosWidth'(3): prog_in = {b, 8'd0};
               PosWidth'(4): prog_in = {prog_in[15:8], b};
               PosWidth'(5): ver_in = b[5:0];
               PosWidth'(6): secn_in = b;
               PosWidth'(7): begin
                  lsec_in = b;
                  if (secn_in > b) begin
                     if (err_in == 3'd0) err_in = STAT_SECNUM;
                     phase_in = PH_DONE;
                  end
               end
               PosWidth'(8): pcr_in = {b[4:0], 8'd0};
               PosWidth'(9): pcr_in = {pcr_in[12:8], b};
               PosWidth'(10): pil_in = {b[3:0], 8'd0};
               PosWidth'(11): begin
                  pil_in = {pil_in[11:8], b};
                  if ({1'b0, pil_in} + {1'b0, HDR_OVERHEAD} > {1'b0, slen_in}) begin
                     if (err_in == 3'd0) err_in = STAT_LENGTH;
                     phase_in = PH_DONE;
                     emit = 1'b1;
                     rec.record_kind = KIND_HEADER;
                     rec.pid = pcr_in;
                     rec.info_length = pil_in;
                  end else begin
                     w12 = slen_in - pil_in - HDR_OVERHEAD;
                     esrem_in = {1'b0, w12};
                     dcnt_in = '0;
                     if (pil_in == 12'd0) begin
                        phase_in = PH_ES0;
                        emit = 1'b1;
                        rec.record_kind = KIND_HEADER;
                        rec.pid = pcr_in;
                     end else begin
                        drem_in = {1'b0, pil_in};
                        walk_in = W_TAG;
                        phase_in = PH_PROG;
                     end
                  end
               end
               default: ;
            endcase
         end
         PH_PROG, PH_ESD: begin
            unique case (walk_in)
               W_TAG: begin
                  if (drem_in >= 13'd2 && dcnt_in < 7'(MaxDescriptors)) begin
                     tag_in = b;
                     dcnt_in = dcnt_in + 1'b1;
                     idb_in = '0;
                     fid_in = '0;
                     if (in_es && esub_in == SUB_UNKNOWN) begin
                        if (est_in == ST_SECTIONS) begin
                           if (b == TAG_APP_SIGNALLING) esub_in = SUB_APP_SIG;
                        end else if (est_in == ST_PES_PRIVATE) begin
                           if (b == TAG_TELETEXT) esub_in = SUB_TELETEXT;
                           else if (b == TAG_SUBTITLING) esub_in = SUB_SUBTITLE;
                           else if (b == TAG_AC3) esub_in = SUB_AC3;
                        end else if (est_in == ST_AC3) begin
                           if (b == TAG_AC3 || b == TAG_AC3_AUDIO) esub_in = SUB_AC3;
                        end
                     end
                     walk_in = W_LEN;
                  end else begin
                     walk_in = W_SKIP;
                  end
               end
               W_LEN: begin
                  dleft_in = b;
                  walk_in = (b != 8'd0) ? W_BODY : W_TAG;
               end
               W_BODY: begin
                  if (in_es && tag_in == TAG_REGISTRATION && idb_in < 3'd4) begin
                     fid_in = {fid_in[23:0], b};
                     idb_in = idb_in + 1'b1;
                     if (idb_in == 3'd4 && esub_in == SUB_UNKNOWN) begin
                        if (est_in == ST_PES_PRIVATE && fid_in == ID_DRA1) esub_in = SUB_DRA;
                        else if (est_in == ST_AC3 && fid_in == ID_AC3) esub_in = SUB_AC3;
                     end
                  end
                  if (dleft_in != 8'd0) dleft_in = dleft_in - 1'b1;
                  if (dleft_in == 8'd0) walk_in = W_TAG;
               end
               default: ;
            endcase
            rem_next = drem_in - 1'b1;
            drem_in = rem_next;
            walk_end = (rem_next == 13'd0);
            if (walk_end) begin
               phase_in = PH_ES0;
               emit = 1'b1;
               if (in_es) begin
                  scnt_in = scnt_in + 1'b1;
                  rec.record_kind = KIND_STREAM;
                  rec.pid = epid_in;
                  rec.es_type = est_in;
                  rec.es_sub = esub_in;
                  rec.info_length = eil_in;
               end else begin
                  rec.record_kind = KIND_HEADER;
                  rec.pid = pcr_in;
                  rec.info_length = pil_in;
               end
               rec.item_count = sat5(dcnt_in);
            end
         end
         PH_ES0: begin
            if (esrem_in >= 13'd5 && scnt_in < 7'(MaxStreams)) begin
               est_in = b; epid_in = '0; eil_in = '0; esub_in = '0;
               dcnt_in = '0;
               phase_in = PH_ES1;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_ES1: begin epid_in = {b[4:0], 8'd0}; phase_in = PH_ES2; end
         PH_ES2: begin epid_in = {epid_in[12:8], b}; phase_in = PH_ES3; end
         PH_ES3: begin eil_in = {b[3:0], 8'd0}; phase_in = PH_ES4; end
         PH_ES4: begin
            eil_in = {eil_in[11:8], b};
            esrem_in = esrem_in - 13'd5;
            if ({1'b0, eil_in} > esrem_in) begin
               if (err_in == 3'd0) err_in = STAT_LENGTH;
               phase_in = PH_DONE;
               emit = 1'b1;
            end else if (eil_in == 12'd0) begin
               phase_in = PH_ES0;
               emit = 1'b1;
            end else begin
               esrem_in = esrem_in - {1'b0, eil_in};
               drem_in = {1'b0, eil_in};
               dcnt_in = '0;
               walk_in = W_TAG;
               phase_in = PH_ESD;
            end
            if (emit) begin
               scnt_in = scnt_in + 1'b1;
               rec.record_kind = KIND_STREAM;
               rec.pid = epid_in;
               rec.es_type = est_in;
               rec.es_sub = esub_in;
               rec.info_length = eil_in;
            end
         end
         default: ;
      endcase
      rec.pgm_num = prog_in;
      rec.version_and_current = ver_in;
      rec.sec_no = secn_in;
      rec.last_sec_no = lsec_in;
      if (in_req.last_byte) begin
         if (bpos < PosWidth'(MinSectionBytes) || bpos > PosWidth'(MaxSectionBytes)) begin
            st = STAT_SIZE;
         end else if (err_in != 3'd0) begin
            st = err_in;
         end else if (crc_in != 32'd0) begin
            st = STAT_CRC;
         end
         emit = 1'b1;
         rec = '0;
         rec.record_kind = KIND_END;
         rec.pgm_num = prog_in;
         rec.version_and_current = ver_in;
         rec.sec_no = secn_in;
         rec.last_sec_no = lsec_in;
         rec.item_count = sat5(scnt_in);
         rec.status = st;
         rec.record_last = 1'b1;
         pos_in = '0; phase_in = PH_HDR; walk_in = W_TAG;
         prog_in = '0; ver_in = '0; secn_in = '0; lsec_in = '0; pcr_in = '0; pil_in = '0;
         slen_in = '0; esrem_in = '0; drem_in = '0; dleft_in = '0; dcnt_in = '0;
         scnt_in = '0; est_in = '0; epid_in = '0; eil_in = '0; esub_in = '0;
         fid_in = '0; err_in = '0; tag_in = '0; idb_in = '0;
         crc_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; phase_ff <= PH_HDR; walk_ff <= W_TAG;
         prog_ff <= '0; ver_ff <= '0; secn_ff <= '0; lsec_ff <= '0; pcr_ff <= '0;
         pil_ff <= '0; slen_ff <= '0; esrem_ff <= '0; drem_ff <= '0; dleft_ff <= '0;
         dcnt_ff <= '0; scnt_ff <= '0; est_ff <= '0; epid_ff <= '0; eil_ff <= '0;
         esub_ff <= '0; fid_ff <= '0; crc_ff <= '1; err_ff <= '0; tag_ff <= '0;
         idb_ff <= '0;
      end else if (in_valid) begin
         pos_ff <= pos_in; phase_ff <= phase_in; walk_ff <= walk_in;
         prog_ff <= prog_in; ver_ff <= ver_in; secn_ff <= secn_in; lsec_ff <= lsec_in;
         pcr_ff <= pcr_in; pil_ff <= pil_in; slen_ff <= slen_in; esrem_ff <= esrem_in;
         drem_ff <= drem_in; dleft_ff <= dleft_in; dcnt_ff <= dcnt_in; scnt_ff <= scnt_in;
         est_ff <= est_in; epid_ff <= epid_in; eil_ff <= eil_in; esub_ff <= esub_in;
         fid_ff <= fid_in; crc_ff <= crc_in; err_ff <= err_in; tag_ff <= tag_in;
         idb_ff <= idb_in;
      end
   end

   assign out_valid = in_valid && emit;
   assign out_rsp   = rec;
endmodule

// ===== sv/pmt_outbuf.sv =====
// ----------------------------------------------------------------------------
// PMT output buffer
// Two-entry skid buffer so the parser keeps taking bytes while a record waits.
// ----------------------------------------------------------------------------
module pmt_outbuf import pmt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  rsp_type wr_rsp,
   output logic    wr_room,
   output logic    rd_valid,
   output rsp_type rd_rsp,
   input  logic    rd_ready
);
   rsp_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_room  = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_rsp   = mem_ff[rptr_ff];
   assign push     = wr_valid && wr_room;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// ===== sv/pmt_section_parser_top.sv =====
// ----------------------------------------------------------------------------
// PMT section parser top level
// Parses MPEG-2 program map sections byte by byte into header, stream and
// end records.
// ----------------------------------------------------------------------------
// Usage: section bytes enter on the req channel, one request per byte, with
// first_byte / last_byte framing. Records leave on the rsp channel: a header
// record after the program descriptor loop, one record per stream entry and
// an end record with status on the last byte. The expected table id sits at
// csr address 0; the user must write it only while the block is idle, as the
// block itself does not enforce this. Throughput: one byte per cycle while
// req_ready is high. A record is buffered when its byte is taken and reaches
// rsp once earlier records are taken. A two-entry output buffer decouples the
// sides: req_ready drops only while both entries hold records the receiver
// has not taken, so a stalled receiver stalls the input after two records.
// Reset: clears the parse state, the CRC to all ones, the output buffer, and
// sets the expected table id to 2.
// ----------------------------------------------------------------------------
module pmt_section_parser_top import pmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pmt_req_if.sink     req,
   pmt_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic       [7:0] exp_tid;
   logic             take;
   logic             rec_valid;
   rsp_type          rec;
   logic             room;

   pmt_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .exp_tid(exp_tid)
   );

   assign req.ready = room;
   assign take      = req.valid && room;

   pmt_parse u_parse (
      .clock(clock), .reset(reset), .in_valid(take), .in_req(req.payload),
      .exp_tid(exp_tid), .out_valid(rec_valid), .out_rsp(rec)
   );

   pmt_outbuf u_outbuf (
      .clock(clock), .reset(reset), .wr_valid(rec_valid), .wr_rsp(rec),
      .wr_room(room), .rd_valid(rsp.valid), .rd_rsp(rsp.payload), .rd_ready(rsp.ready)
   );

   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.payload.record_last == (rsp.payload.record_kind == KIND_END)))
      else $error("record_last disagrees with record kind");

   a_last_byte_record: assert property (@(posedge clock) disable iff (reset)
      (take && req.payload.last_byte) |=> rsp.valid)
      else $error("no record after last byte");

   a_status_only_end: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload.record_kind != KIND_END) |-> rsp.payload.status == STAT_OK)
      else $error("status on non-end record");
endmodule
